>>> src/ese_pkg.sv
// Shared types and constants for the exponential search engine.
package ese_pkg;

    localparam int IDX_W = 10;
    localparam int VAL_W = 32;
    localparam int CNT_W = 11;

    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_SEARCH = 1'b1;

    typedef struct packed {
        logic                    func;
        logic [IDX_W-1:0]        entry_index;
        logic signed [VAL_W-1:0] entry_value;
        logic signed [VAL_W-1:0] search_key;
    } t_in_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] match_index;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHK0,
        S_EXP,
        S_BSET,
        S_BIN,
        S_DONE
    } t_state;

endpackage

>>> src/ese_front.sv
// Front end: accepts input beats, classifies them and queues them for the engine.
module ese_front
    import ese_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  t_in_item                    i_in_data,
    output logic                        o_q_valid,
    output logic                        o_q_search,
    output logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] o_q_addr,
    output logic signed [KEY_WIDTH-1:0] o_q_key,
    input  logic                        i_q_pop
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef struct packed {
        logic                        search;
        logic [AW-1:0]               addr;
        logic signed [KEY_WIDTH-1:0] key;
    } t_q_entry;

    t_q_entry   r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    t_q_entry   entry;
    logic       is_search;
    logic       in_range;
    logic       keep;
    logic       push;
    logic       full;

    assign full      = (r_count == 2'd2);
    assign is_search = (i_in_data.func == FUNC_SEARCH);
    assign in_range  = (32'(i_in_data.entry_index) < 32'(TABLE_DEPTH));
    // drop writes beyond the table: they leave no trace
    assign keep      = is_search || in_range;
    assign push      = i_in_valid && !full && keep;

    always_comb begin
        entry.search = is_search;
        entry.addr   = AW'(i_in_data.entry_index);
        entry.key    = is_search ? KEY_WIDTH'(i_in_data.search_key)
                                 : KEY_WIDTH'(i_in_data.entry_value);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_in_stall = full;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_search = r_slot[r_rd_ptr].search;
    assign o_q_addr   = r_slot[r_rd_ptr].addr;
    assign o_q_key    = r_slot[r_rd_ptr].key;

endmodule

>>> src/ese_engine.sv
// Back end: key table memory, search sequencer and result register.
module ese_engine
    import ese_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CNT_W-1:0]            i_cfg_data,
    input  logic                        i_q_valid,
    input  logic                        i_q_search,
    input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] i_q_addr,
    input  logic signed [KEY_WIDTH-1:0] i_q_key,
    output logic                        o_q_pop,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output t_out_item                   o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW = AW + 1;

    logic [KEY_WIDTH-1:0]        r_mem [TABLE_DEPTH];
    logic signed [KEY_WIDTH-1:0] r_rd_data;
    logic [CNT_W-1:0]            r_entry_count;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_n, n_n;
    logic signed [KEY_WIDTH-1:0] r_key, n_key;
    logic [IW-1:0]               r_bound, n_bound;
    logic [IW-1:0]               r_lo, n_lo;
    logic [IW-1:0]               r_hi, n_hi;
    logic [IW-1:0]               r_mid, n_mid;
    logic                        r_found, n_found;
    logic [IW-1:0]               r_match, n_match;
    logic                        r_out_valid, n_out_valid;
    t_out_item                   r_out, n_out;

    logic [AW-1:0] rd_addr;
    logic          mem_we;
    logic [IW-1:0] sat_n;
    logic          probe_eq;
    logic          probe_lt;
    logic [IW-1:0] bound2;
    logic          bound2_in;
    logic [IW:0]   sum_up;
    logic [IW:0]   sum_dn;
    logic [IW:0]   sum_set;
    logic [IW-1:0] mid_up;
    logic [IW-1:0] mid_dn;
    logic [IW-1:0] mid_set;
    logic          cont_up;
    logic          cont_dn;
    logic          out_free;

    assign sat_n = (32'(r_entry_count) > 32'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH)
                                                           : IW'(r_entry_count);
    assign probe_eq  = (r_rd_data == r_key);
    assign probe_lt  = (r_rd_data < r_key);
    assign bound2    = {r_bound[IW-2:0], 1'b0};
    assign bound2_in = (bound2 < r_n);
    // both candidate midpoints are formed ahead of the compare
    assign sum_up    = {1'b0, r_mid} + {1'b0, r_hi} + {{IW{1'b0}}, 1'b1};
    assign sum_dn    = {1'b0, r_lo} + {1'b0, r_mid} - {{IW{1'b0}}, 1'b1};
    assign sum_set   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_up    = sum_up[IW:1];
    assign mid_dn    = sum_dn[IW:1];
    assign mid_set   = sum_set[IW:1];
    assign cont_up   = (r_mid < r_hi);
    assign cont_dn   = (r_lo < r_mid);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[i_q_addr] <= i_q_key;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid && i_q_search) begin
                    n_state = (sat_n == '0) ? S_DONE : S_CHK0;
                end
            end
            S_CHK0: begin
                if (probe_eq) begin
                    n_state = S_DONE;
                end else if (r_n > IW'(1)) begin
                    n_state = S_EXP;
                end else begin
                    n_state = S_BSET;
                end
            end
            S_EXP: begin
                if (!(probe_lt && bound2_in)) begin
                    n_state = S_BSET;
                end
            end
            S_BSET: n_state = S_BIN;
            S_BIN: begin
                if (probe_eq) begin
                    n_state = S_DONE;
                end else if (probe_lt) begin
                    n_state = cont_up ? S_BIN : S_DONE;
                end else begin
                    n_state = cont_dn ? S_BIN : S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and handshake outputs
    always_comb begin
        n_n         = r_n;
        n_key       = r_key;
        n_bound     = r_bound;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_match     = r_match;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        rd_addr     = '0;
        mem_we      = 1'b0;
        o_q_pop     = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q_search) begin
                        n_key   = i_q_key;
                        n_n     = sat_n;
                        n_found = 1'b0;
                        n_match = '0;
                    end else begin
                        mem_we = 1'b1;
                    end
                end
            end
            S_CHK0: begin
                if (probe_eq) begin
                    n_found = 1'b1;
                    n_match = '0;
                end else begin
                    n_bound = IW'(1);
                    rd_addr = AW'(1);
                    n_lo    = '0;
                    n_hi    = '0;
                end
            end
            S_EXP: begin
                if (probe_lt && bound2_in) begin
                    n_bound = bound2;
                    rd_addr = bound2[AW-1:0];
                end else if (probe_lt) begin
                    n_lo = r_bound;
                    n_hi = r_n - IW'(1);
                end else begin
                    n_lo = r_bound >> 1;
                    n_hi = r_bound;
                end
            end
            S_BSET: begin
                n_mid   = mid_set;
                rd_addr = mid_set[AW-1:0];
            end
            S_BIN: begin
                if (probe_eq) begin
                    n_found = 1'b1;
                    n_match = r_mid;
                end else if (probe_lt) begin
                    n_lo    = r_mid + IW'(1);
                    n_mid   = mid_up;
                    rd_addr = mid_up[AW-1:0];
                end else begin
                    n_hi    = r_mid - IW'(1);
                    n_mid   = mid_dn;
                    rd_addr = mid_dn[AW-1:0];
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = r_found;
                    n_out.match_index = IDX_W'(r_match);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_key   <= n_key;
        r_bound <= n_bound;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_match <= n_match;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_entry_count <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> src/exponential_search_engine_unit.sv
// Top level of the exponential search engine: front queue plus search engine.
//
//   channel   direction  handshake               beat
//   in        input      i_in_valid/o_in_stall    t_in_item (write or search)
//   out       output     o_out_valid/i_out_stall  t_out_item (one per search)
//   cfg       input      i_cfg_we                 entry_count, 11 bits
//
// A write beat is handled in the engine's idle state. A search takes one table read per
// cycle: entry 0, up to log2(count) doubling probes, a setup step, up to log2(count)+1
// midpoint probes and a result step that waits while i_out_stall holds the result
// register; the single read port of the key table sets this pace.
// A two-beat queue decouples input from the engine; the result register lets
// the next beat start while a result waits under i_out_stall.
// Reset clears the count, queue and control state; table contents are kept.
module exponential_search_engine_unit
    import ese_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int KEY_WIDTH   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CNT_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic                        q_valid;
    logic                        q_search;
    logic [AW-1:0]               q_addr;
    logic signed [KEY_WIDTH-1:0] q_key;
    logic                        q_pop;

    ese_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_q_valid  (q_valid),
        .o_q_search (q_search),
        .o_q_addr   (q_addr),
        .o_q_key    (q_key),
        .i_q_pop    (q_pop)
    );

    ese_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_search  (q_search),
        .i_q_addr    (q_addr),
        .i_q_key     (q_key),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

>>> dv/ese_tb_pkg.sv
// Scoreboard for the exponential search engine: table shadow, search prediction, result check.
package ese_tb_pkg;
    import ese_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TBL_DEPTH = 1024;
    localparam bit signed [VAL_W-1:0] KEY_MIN = 32'sh8000_0000;
    localparam bit signed [VAL_W-1:0] KEY_MAX = 32'sh7FFF_FFFF;

    class lookup_scoreboard;
        bit signed [VAL_W-1:0] key_tbl [TBL_DEPTH];
        bit [CNT_W-1:0]        entry_count;
        t_out_item             expected_lookups [$];
        int                    errors;

        function new();
            entry_count = '0;
            errors      = 0;
        endfunction

        // Exponential probe from entry 0, then binary search over the last doubling step.
        function t_out_item exp_search(bit signed [VAL_W-1:0] key);
            t_out_item r;
            int        n;
            int        bound;
            int        lo;
            int        hi;
            int        mid;
            r = '0;
            n = (entry_count > TBL_DEPTH) ? TBL_DEPTH : int'(entry_count);
            if (n == 0) return r;
            if (key_tbl[0] == key) begin
                r.found = 1'b1;
                return r;
            end
            bound = 1;
            while (bound < n && key_tbl[bound] < key) bound = bound * 2;
            lo = bound / 2;
            hi = (bound < n - 1) ? bound : n - 1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (key_tbl[mid] == key) begin
                    r.found       = 1'b1;
                    r.match_index = IDX_W'(mid);
                    return r;
                end
                if (key_tbl[mid] < key) begin
                    lo = mid + 1;
                end else begin
                    if (mid == 0) break;
                    hi = mid - 1;
                end
            end
            return r;
        endfunction

        function void note_beat(t_in_item b);
            if (b.func == FUNC_WRITE) begin
                key_tbl[b.entry_index] = b.entry_value;
            end else begin
                expected_lookups.push_back(exp_search(b.search_key));
            end
        endfunction

        function void check_beat(t_out_item got);
            t_out_item want;
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result beat found=%0d index=%0d",
                         $time, got.found, got.match_index);
                errors++;
                return;
            end
            want = expected_lookups.pop_front();
            if (got.found !== want.found || got.match_index !== want.match_index) begin
                if (got.found !== want.found)
                    $display("%0t: found mismatch expected %0d actual %0d",
                             $time, want.found, got.found);
                if (got.match_index !== want.match_index)
                    $display("%0t: match_index mismatch expected %0d actual %0d",
                             $time, want.match_index, got.match_index);
                errors++;
            end
        endfunction

        function int pending();
            return expected_lookups.size();
        endfunction
    endclass

endpackage

>>> dv/tb_top.sv
// Top-level testbench for exponential_search_engine_unit: stimulus, stall bursts and checking.
module tb_top;
    import ese_pkg::*;
    import ese_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS         = 1350;
    localparam int SETTLE_CYCLES = 64;
    localparam int QUIET_LIMIT   = 3000;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CNT_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_in_item         i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_out_item        o_out_data;

    lookup_scoreboard sb;
    bit               idle_on  = 1'b1;
    int               out_hold = 0;
    int               quiet    = 0;
    int               sent     = 0;

    exponential_search_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side in bursts.
    always @(posedge i_clk) begin
        if (out_hold > 0) begin
            out_hold--;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_hold = $urandom_range(1, 14);
        end
        i_out_stall <= (out_hold > 0);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_beat(o_out_data);
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) quiet = 0;
            else quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    task automatic send_beat(input t_in_item b);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_beat(b);
        sent++;
    endtask

    task automatic write_entry(input int idx, input logic signed [VAL_W-1:0] val);
        t_in_item b;
        b.func        = FUNC_WRITE;
        b.entry_index = IDX_W'(idx);
        b.entry_value = val;
        b.search_key  = $urandom;
        send_beat(b);
    endtask

    task automatic search_for(input logic signed [VAL_W-1:0] key);
        t_in_item b;
        b.func        = FUNC_SEARCH;
        b.entry_index = IDX_W'($urandom);
        b.entry_value = $urandom;
        b.search_key  = key;
        send_beat(b);
    endtask

    // Drop valid, drain all pending results, then let trailing writes retire.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_count(input int n);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CNT_W'(n);
        @(posedge i_clk);
        i_cfg_we       <= 1'b0;
        sb.entry_count  = CNT_W'(n);
    endtask

    // Write entries 0..n-1 in ascending order; zero steps make duplicates.
    task automatic fill_prefix(input int n);
        longint v;
        longint step_max;
        int     mode;
        mode = $urandom_range(0, 2);
        case (mode)
            0:       step_max = 3;
            1:       step_max = 1000;
            default: step_max = 64'h1_0000_0000 / (n + 1);
        endcase
        if ($urandom_range(0, 3) == 0 || mode == 2)
            v = longint'(KEY_MIN) + longint'($urandom_range(0, 1000));
        else v = longint'($signed($urandom));
        for (int i = 0; i < n; i++) begin
            write_entry(i, VAL_W'(v));
            v = v + longint'($urandom_range(0, 32'(step_max)));
            if (v > KEY_MAX) v = KEY_MAX;
        end
    endtask

    function automatic logic signed [VAL_W-1:0] pick_key(input int n);
        int                       nn;
        int                       j;
        logic signed [VAL_W-1:0]  k;
        nn = (n > TBL_DEPTH) ? TBL_DEPTH : n;
        j  = (nn > 0) ? $urandom_range(0, nn - 1) : 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: k = (nn > 0) ? sb.key_tbl[j] : $urandom;
            5:             k = sb.key_tbl[j] + 1;
            6:             k = sb.key_tbl[j] - 1;
            7:             k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
            default:       k = $urandom;
        endcase
        return k;
    endfunction

    initial begin
        int                      n;
        int                      beats;
        int                      idx;
        bit                      refill;
        bit                      big_done;
        logic signed [VAL_W-1:0] val;

        sb = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty table after reset: always a miss.
        search_for(32'sd0);
        search_for(KEY_MIN);

        write_entry(0, KEY_MIN);
        write_entry(1, -32'sd5);
        write_entry(2, -32'sd5);
        write_entry(3, 32'sd7);
        write_entry(4, KEY_MAX);
        write_entry(TBL_DEPTH - 1, 32'sh5A5A_A5A5);
        set_count(5);
        search_for(KEY_MIN);
        search_for(-32'sd5);
        search_for(32'sd7);
        search_for(KEY_MAX);
        search_for(32'sd0);
        search_for(KEY_MIN + 1);
        search_for(32'sd8);
        search_for(-32'sd6);
        search_for(KEY_MAX - 1);

        // Break the ordering and probe around the hole.
        write_entry(2, KEY_MAX);
        search_for(32'sd7);
        search_for(KEY_MAX);
        search_for(-32'sd5);

        big_done = 1'b0;
        while (sent < ITEMS) begin
            idle_on = (sent < ITEMS - 150) && ($urandom_range(0, 3) != 0);
            if (!big_done && sent >= 150) begin
                n        = TBL_DEPTH;
                refill   = 1'b1;
                big_done = 1'b1;
            end else if (big_done && $urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 4))
                    0:       n = TBL_DEPTH;
                    1:       n = 2047;
                    2:       n = TBL_DEPTH - 1;
                    3:       n = 513;
                    default: n = $urandom_range(65, TBL_DEPTH);
                endcase
                refill = 1'b0;
            end else begin
                case ($urandom_range(0, 5))
                    0:       n = 0;
                    1:       n = 1;
                    2:       n = 2;
                    3:       n = 3;
                    4:       n = $urandom_range(4, 20);
                    default: n = $urandom_range(21, 80);
                endcase
                refill = 1'b1;
            end
            set_count(n);
            if (refill) fill_prefix(n);
            beats = $urandom_range(10, 40);
            repeat (beats) begin
                if ($urandom_range(0, 4) == 0) begin
                    idx = $urandom_range(0, TBL_DEPTH - 1);
                    // Mostly copy the left neighbor so the table stays sorted.
                    if ($urandom_range(0, 3) == 0) val = $urandom;
                    else val = (idx > 0) ? sb.key_tbl[idx - 1] : KEY_MIN;
                    write_entry(idx, val);
                end else begin
                    search_for(pick_key(n));
                end
            end
        end

        idle_on = 1'b0;
        settle();
        if (sb.errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

endmodule

>>> files.f
src/ese_pkg.sv
src/ese_front.sv
src/ese_engine.sv
src/exponential_search_engine_unit.sv
dv/ese_tb_pkg.sv
dv/tb_top.sv
